// ===== src/rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtp_pkg: shared types and constants for the reload timer
// Command and response words, register offsets, control bit positions.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 32;
    localparam int DATA_WIDTH          = 32;
    localparam int ADDR_WIDTH          = 8;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_IDLE  = 2'd3
    } rtp_action_t;

    typedef enum logic [1:0] {
        RESP_OK       = 2'd0,
        RESP_CMD_ERR  = 2'd1,
        RESP_ADDR_ERR = 2'd2
    } rtp_resp_t;

    localparam logic [ADDR_WIDTH-1:0] ADDR_CONTROL   = 8'd0;
    localparam logic [ADDR_WIDTH-1:0] ADDR_RELOAD    = 8'd4;
    localparam logic [ADDR_WIDTH-1:0] ADDR_PENDING   = 8'd8;
    localparam logic [ADDR_WIDTH-1:0] ADDR_REMAINING = 8'd12;

    // control register bit positions
    localparam int CTRL_EN  = 0;
    localparam int CTRL_PER = 1;
    localparam int CTRL_IRQ = 2;

    // bits that must be zero on control and pending writes
    localparam logic [DATA_WIDTH-1:0] CTRL_RSVD_MASK = ~32'd7;
    localparam logic [DATA_WIDTH-1:0] PEND_RSVD_MASK = ~32'd1;

    typedef struct packed {
        rtp_action_t                 action;
        logic [ADDR_WIDTH-1:0]       address;
        logic [DATA_WIDTH-1:0]       write_data;
    } rtp_cmd_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]       read_data;
        rtp_resp_t                   response;
        logic                        irq;
    } rtp_rsp_t;

endpackage

`default_nettype wire

// ===== src/rtp_in_stage.sv =====
// ----------------------------------------------------------------------------
// rtp_in_stage: command input register
// Captures one command word per cycle while cmd_stall is low and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_in_stage
    import rtp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire rtp_cmd_t cmd_data,
    input  wire logic     advance,
    output logic          held_valid,
    output rtp_cmd_t      held_cmd
);

    logic     valid_reg;
    logic     valid_next;
    rtp_cmd_t cmd_reg;
    logic     take;

    // full register is freed in the same cycle the core consumes it
    assign cmd_stall  = valid_reg && !advance;
    assign take       = cmd_valid && !cmd_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_cmd   = cmd_reg;

endmodule

`default_nettype wire

// ===== src/rtp_core.sv =====
// ----------------------------------------------------------------------------
// rtp_core: timer state and register file
// Applies one command word per advance and forms its response word.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_core
    import rtp_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [DATA_WIDTH-1:0] cfg_wdata,
    input  wire logic                  advance,
    input  wire rtp_cmd_t              cmd,
    output rtp_rsp_t                   rsp
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic [2:0]             ctrl_reg,      ctrl_next;
    logic [COUNT_WIDTH-1:0] reload_reg,    reload_next;
    logic [COUNT_WIDTH-1:0] countdown_reg, countdown_next;
    logic                   pending_reg,   pending_next;
    logic                   fired_reg,     fired_next;

    logic [DATA_WIDTH-1:0]  rd;
    rtp_resp_t              resp;
    logic [DATA_WIDTH-1:0]  wd;
    logic [COUNT_WIDTH-1:0] wd_cnt;
    logic                   reload_ok;
    logic [COUNT_WIDTH-1:0] cfg_cnt;

    assign wd        = cmd.write_data;
    assign wd_cnt    = wd[COUNT_WIDTH-1:0];
    assign reload_ok = (wd != '0) && ((wd >> COUNT_WIDTH) == '0);
    assign cfg_cnt   = (cfg_wdata[COUNT_WIDTH-1:0] == '0) ? CNT_ONE
                                                          : cfg_wdata[COUNT_WIDTH-1:0];

    always_comb
    begin
        ctrl_next      = ctrl_reg;
        reload_next    = reload_reg;
        countdown_next = countdown_reg;
        pending_next   = pending_reg;
        fired_next     = fired_reg;
        rd             = '0;
        resp           = RESP_OK;

        unique case (cmd.action)
            ACT_TICK:
            begin
                fired_next = 1'b0;
                if (ctrl_reg[CTRL_EN])
                begin
                    if (countdown_reg > CNT_ONE)
                    begin
                        countdown_next = countdown_reg - CNT_ONE;
                    end
                    else
                    begin
                        // expiry: zero or one left
                        pending_next = 1'b1;
                        fired_next   = 1'b1;
                        if (ctrl_reg[CTRL_PER])
                        begin
                            countdown_next = reload_reg;
                        end
                        else
                        begin
                            countdown_next      = '0;
                            ctrl_next[CTRL_EN]  = 1'b0;
                        end
                    end
                end
            end

            ACT_READ:
            begin
                unique case (cmd.address)
                    ADDR_CONTROL:   rd = DATA_WIDTH'(ctrl_reg);
                    ADDR_RELOAD:    rd = DATA_WIDTH'(reload_reg);
                    ADDR_PENDING:   rd = DATA_WIDTH'(pending_reg);
                    ADDR_REMAINING: rd = ctrl_reg[CTRL_EN] ? DATA_WIDTH'(countdown_reg) : '0;
                    default:        resp = RESP_ADDR_ERR;
                endcase
            end

            ACT_WRITE:
            begin
                unique case (cmd.address)
                    ADDR_CONTROL:
                    begin
                        if ((wd & CTRL_RSVD_MASK) != '0)
                        begin
                            resp = RESP_CMD_ERR;
                        end
                        else
                        begin
                            ctrl_next = wd[2:0];
                            if (wd[CTRL_EN])
                            begin
                                countdown_next = reload_reg;
                            end
                        end
                    end
                    ADDR_RELOAD:
                    begin
                        if (!reload_ok)
                        begin
                            resp = RESP_CMD_ERR;
                        end
                        else
                        begin
                            reload_next = wd_cnt;
                            if (ctrl_reg[CTRL_EN])
                            begin
                                countdown_next = wd_cnt;
                            end
                        end
                    end
                    ADDR_PENDING:
                    begin
                        if ((wd & PEND_RSVD_MASK) != '0)
                        begin
                            resp = RESP_CMD_ERR;
                        end
                        else if (wd[0] && !fired_reg)
                        begin
                            // write one to clear, expiry on the last tick wins
                            pending_next = 1'b0;
                        end
                    end
                    ADDR_REMAINING: resp = RESP_CMD_ERR;
                    default:        resp = RESP_ADDR_ERR;
                endcase
            end

            ACT_IDLE:
            begin
                rd = '0;
            end

            default:
            begin
                rd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            reload_reg    <= CNT_ONE;
            countdown_reg <= '0;
            pending_reg   <= 1'b0;
            fired_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            reload_reg <= cfg_cnt;
        end
        else if (advance)
        begin
            ctrl_reg      <= ctrl_next;
            reload_reg    <= reload_next;
            countdown_reg <= countdown_next;
            pending_reg   <= pending_next;
            fired_reg     <= fired_next;
        end
    end

    assign rsp.read_data = rd;
    assign rsp.response  = resp;
    assign rsp.irq       = pending_next && ctrl_next[CTRL_IRQ];

endmodule

`default_nettype wire

// ===== src/rtp_out_stage.sv =====
// ----------------------------------------------------------------------------
// rtp_out_stage: response output register
// Holds one response word; reloads in the cycle the old one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_out_stage
    import rtp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load_req,
    input  wire rtp_rsp_t load_rsp,
    output logic          advance,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output rtp_rsp_t      rsp_data
);

    logic     valid_reg;
    logic     valid_next;
    rtp_rsp_t rsp_reg;
    logic     can_load;

    assign can_load   = !valid_reg || !rsp_stall;
    assign advance    = load_req && can_load;
    assign valid_next = advance || (valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= load_rsp;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

// ===== src/reload_timer_with_pending_irq.sv =====
// ----------------------------------------------------------------------------
// reload_timer_with_pending_irq: down-counting reload timer with sticky irq
// Each command word is a tick, a register read or a register write; each
// command produces exactly one response word (read data, status, irq level).
//
// Channels: cmd_* carries command words in, rsp_* carries response words out.
// A word moves on a rising edge where valid is high and stall is low.
// Order: a command taken into the input register is applied to the timer
// state at the edge where the response register loads its response word.
// Throughput: one command per cycle unless stalled; the input and response
// registers each keep a word, so a command is taken while a response waits.
// Receiver stall: the response register holds its word; the command in the
// input register waits, and cmd_stall rises once that register is full.
// Config: cfg_we loads cfg_wdata directly as reload value, masked to COUNT_WIDTH
// bits, zero forced to one; the user must write it only while idle (unchecked).
// Reset (rst_n low, asynchronous): control bits, countdown and pending
// clear, reload value becomes one, both registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module reload_timer_with_pending_irq
    import rtp_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [DATA_WIDTH-1:0] cfg_wdata,

    // command channel
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire rtp_cmd_t              cmd_data,

    // response channel
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output rtp_rsp_t                   rsp_data
);

    // held command between input register and core
    logic     held_valid;
    rtp_cmd_t held_cmd;

    // core result feeding the response register
    rtp_rsp_t core_rsp;

    // core applies the held command when the response register can take it
    logic     advance;

    rtp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_data   (cmd_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_cmd   (held_cmd)
    );

    rtp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .cmd       (held_cmd),
        .rsp       (core_rsp)
    );

    rtp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_req  (held_valid),
        .load_rsp  (core_rsp),
        .advance   (advance),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire
